@@ sv/mm3_pkg.sv @@
// Shared types, constants and helpers for the MurmurHash3 x86_32 stream hash unit.
package mm3_pkg;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] MIX_ADD = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned REG_SEL_BIT = 2;
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_FIN1,
    ST_FIN2,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_C1,
    MUL_C2,
    MUL_F1,
    MUL_F2
  } mul_op_t;

  typedef struct packed {
    logic    accept;
    mul_op_t op;
    logic    mix;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

endpackage

@@ sv/mm3_ctrl.sv @@
// Sequencer for the hash unit: steps each word through multiply and mix, and the last word through finalize.
module mm3_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  mm3_pkg::stat_t stat,
  output mm3_pkg::cmd_t  cmd
);
  import mm3_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MIX;
      ST_MIX: begin
        if (stat.last) state_nxt = ST_FIN1;
        else if (in_tvalid) state_nxt = ST_MUL1;
        else state_nxt = ST_IDLE;
      end
      ST_FIN1: state_nxt = ST_FIN2;
      ST_FIN2: state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.op       = MUL_NONE;
    cmd.mix      = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_MUL1: cmd.op = MUL_C1;
      ST_MUL2: cmd.op = MUL_C2;
      ST_MIX: begin
        cmd.mix   = 1'b1;
        in_tready = !stat.last;
      end
      ST_FIN1: cmd.op = MUL_F1;
      ST_FIN2: cmd.op = MUL_F2;
      ST_OUT:  cmd.load_out = out_free;
      default: in_tready = 1'b0;
    endcase
    cmd.accept = in_tready && in_tvalid;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/mm3_dpath.sv @@
// Datapath for the hash unit: word capture, shared multiplier, running hash and length.
module mm3_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  mm3_pkg::cmd_t  cmd,
  output mm3_pkg::stat_t stat,
  input  logic [31:0]    seed,
  input  logic [31:0]    in_word,
  input  logic [2:0]     in_byte_count,
  input  logic           in_last,
  output logic [31:0]    out_hash
);
  import mm3_pkg::*;

  logic [31:0] k_r, k_nxt;
  logic        full_r, full_nxt;
  logic [1:0]  tail_n_r, tail_n_nxt;
  logic        last_r;
  logic [31:0] p_r;
  logic [31:0] h_r, h_nxt;
  logic [31:0] len_r, len_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [31:0] out_r;
  logic [31:0] mul_a, mul_b, fin_x;
  logic [31:0] prod;

  // Capture: non-last words and counts of four or more are full blocks.
  always_comb begin
    full_nxt   = !in_last || (in_byte_count >= 3'd4);
    tail_n_nxt = in_byte_count[1:0];
    k_nxt      = in_word;
    if (!full_nxt) begin
      case (tail_n_nxt)
        2'd0:    k_nxt = 32'h0;
        2'd1:    k_nxt = {24'h0, in_word[7:0]};
        2'd2:    k_nxt = {16'h0, in_word[15:0]};
        2'd3:    k_nxt = {8'h0, in_word[23:0]};
        default: k_nxt = 32'h0;
      endcase
    end
  end

  // Shared multiplier, one product per cycle, kept modulo 2^32.
  always_comb begin
    fin_x = h_r ^ len_r;
    mul_a = k_r;
    mul_b = C1;
    case (cmd.op)
      MUL_C1: begin mul_a = k_r;                  mul_b = C1; end
      MUL_C2: begin mul_a = rotl15(p_r);          mul_b = C2; end
      MUL_F1: begin mul_a = fin_x ^ (fin_x >> 16); mul_b = F1; end
      MUL_F2: begin mul_a = p_r ^ (p_r >> 13);    mul_b = F2; end
      default: begin mul_a = k_r;                 mul_b = C1; end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    h_nxt      = h_r;
    len_nxt    = len_r;
    in_msg_nxt = in_msg_r;
    if (cmd.mix) begin
      if (full_r) begin
        h_nxt   = (rotl13(h_r ^ p_r) << 2) + rotl13(h_r ^ p_r) + MIX_ADD;
        len_nxt = len_r + 32'd4;
      end else begin
        h_nxt   = h_r ^ p_r;
        len_nxt = len_r + {30'h0, tail_n_r};
      end
      if (last_r) in_msg_nxt = 1'b0;
    end
    if (cmd.accept) begin
      if (!in_msg_r) begin
        h_nxt   = seed;
        len_nxt = 32'h0;
      end
      in_msg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r      <= 32'h0;
      len_r    <= 32'h0;
      in_msg_r <= 1'b0;
    end else begin
      h_r      <= h_nxt;
      len_r    <= len_nxt;
      in_msg_r <= in_msg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      k_r      <= k_nxt;
      full_r   <= full_nxt;
      tail_n_r <= tail_n_nxt;
      last_r   <= in_last;
    end
    if (cmd.op != MUL_NONE) p_r <= prod;
    if (cmd.load_out) out_r <= p_r ^ (p_r >> 16);
  end

  assign stat.last = last_r;
  assign out_hash  = out_r;

endmodule

@@ sv/murmur3_32_stream_hash_unit.sv @@
// Flow: an accepted non-last word is scrambled by two multiplies (MUL1, MUL2), then mixed;
//   the next word is taken in its mix cycle, so a message streams through one shared multiplier,
//   two products per block.
// Last word: the mix is followed by two finalizer multiplies, then the result is loaded
//   and shows on out_tvalid; the next word is taken in IDLE after that, later while a held result stalls.
// Reset: synchronous, active low; clears seed, running hash, length and the FSM.
module murmur3_32_stream_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  // APB-style configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mm3_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] word, [34:32] byte_count, [39:35] zero
  input  logic        in_tlast,   // last word of the message
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] hash
);
  import mm3_pkg::*;

  logic [31:0] seed_r, seed_nxt;
  logic        cfg_wr;
  logic        sel_seed;
  cmd_t        cmd;
  stat_t       stat;

  // Register file: one word-aligned register, the seed. Other addresses drop writes.
  assign cfg_pready = 1'b1;
  assign sel_seed   = (cfg_paddr[REG_SEL_BIT] == REG_SEED);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    seed_nxt = seed_r;
    if (cfg_wr && sel_seed) seed_nxt = cfg_pwdata;
  end

  assign cfg_prdata = sel_seed ? seed_r : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= 32'h0;
    else        seed_r <= seed_nxt;
  end

  // Sequencer: owns handshakes and the output valid flag.
  mm3_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: seed is sampled when the first word of a message is taken.
  mm3_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .seed          (seed_r),
    .in_word       (in_tdata[31:0]),
    .in_byte_count (in_tdata[34:32]),
    .in_last       (in_tlast),
    .out_hash      (out_tdata)
  );

`ifndef SYNTHESIS
  // Every accepted word occupies the multiplier through MUL1 and MUL2, so input is never accepted back to back.
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted back to back");

  // The output register is only reloaded when free or being drained.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result overwritten before transaction");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not presented");

  // Mixing uses the second scramble product from the previous cycle.
  a_mix_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix |-> $past(cmd.op == MUL_C2))
    else $error("mix without preceding scramble multiply");
`endif

endmodule
